// File: design/fta_pkg.sv
// Shared widths, register codes, reset values and types of the fixed-timestep accumulator.
package fta_pkg;

  // Field widths
  localparam int unsigned RAW_W    = 40;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned NS_W     = 32;
  localparam int unsigned SD_W     = 40;
  localparam int unsigned ACC_W    = 41;
  localparam int unsigned TOTAL_W  = 63;
  localparam int unsigned FRAME_W  = 48;
  localparam int unsigned STEP_W   = 6;
  localparam int unsigned ALPHA_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // Default bound on the per-frame step budget
  localparam int unsigned MAX_STEPS_BOUND_DEF = 63;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS  = 3'd4;

  // Register reset values
  localparam logic [SCALE_W-1:0] TIME_SCALE_RST = 16'd256;
  localparam logic [NS_W-1:0]    MAX_DELTA_RST  = 32'd250000000;
  localparam logic [NS_W-1:0]    FIXED_STEP_RST = 32'd16666667;
  localparam logic [STEP_W-1:0]  MAX_STEPS_RST  = 6'd8;

  // Configuration seen by the core
  typedef struct packed {
    logic               paused;
    logic [SCALE_W-1:0] time_scale_q8;
    logic [NS_W-1:0]    max_delta_ns;
    logic [NS_W-1:0]    fixed_step_ns;
    logic [STEP_W-1:0]  max_steps;
  } fta_cfg_t;

endpackage

// File: design/fta_cfg.sv
// Configuration register file with write sanitising.
module fta_cfg import fta_pkg::*; #(
  parameter int unsigned MAX_STEPS_BOUND = MAX_STEPS_BOUND_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output fta_cfg_t             cfg_o
);

  localparam logic [STEP_W-1:0] Bound = STEP_W'(MAX_STEPS_BOUND);

  fta_cfg_t          cfg_q, cfg_d;
  logic [STEP_W-1:0] steps_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Saturate the step budget into one to the bound
  always_comb begin
    steps_wr = cfg_data_i[STEP_W-1:0];
    if (steps_wr == '0) begin
      steps_wr = STEP_W'(1);
    end
    if (steps_wr > Bound) begin
      steps_wr = Bound;
    end
  end

  // Decode a write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PAUSED:     cfg_d.paused        = cfg_data_i[0];
        CFG_TIME_SCALE: cfg_d.time_scale_q8 = cfg_data_i[SCALE_W-1:0];
        CFG_MAX_DELTA:  cfg_d.max_delta_ns  = cfg_data_i[NS_W-1:0];
        CFG_FIXED_STEP: begin
          // a zero step length is ignored
          if (cfg_data_i[NS_W-1:0] != '0) begin
            cfg_d.fixed_step_ns = cfg_data_i[NS_W-1:0];
          end
        end
        CFG_MAX_STEPS:  cfg_d.max_steps     = steps_wr;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.paused        <= 1'b0;
      cfg_q.time_scale_q8 <= TIME_SCALE_RST;
      cfg_q.max_delta_ns  <= MAX_DELTA_RST;
      cfg_q.fixed_step_ns <= FIXED_STEP_RST;
      cfg_q.max_steps     <= MAX_STEPS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: design/fta_alu.sv
// Shared subtract-and-compare unit against the fixed step length.
module fta_alu import fta_pkg::*; (
  input  logic [ACC_W-1:0] a_i,
  input  logic [NS_W-1:0]  b_i,
  output logic [ACC_W-1:0] diff_o,
  output logic             ge_o
);

  logic [ACC_W:0] diff;

  // Subtract with a borrow bit; no borrow means a is at least b
  assign diff   = {1'b0, a_i} - {(ACC_W + 1 - NS_W)'(0), b_i};
  assign diff_o = diff[ACC_W-1:0];
  assign ge_o   = ~diff[ACC_W];

endmodule

// File: design/fta_core.sv
// Frame sequencer: clamp, scale, accumulate, grant steps and divide out alpha.
module fta_core import fta_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fta_cfg_t           cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [RAW_W-1:0]   raw_delta_ns_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               is_step_o,
  output logic [STEP_W-1:0]  step_index_o,
  output logic [SD_W-1:0]    scaled_delta_ns_o,
  output logic [NS_W-1:0]    unscaled_delta_ns_o,
  output logic [ALPHA_W-1:0] alpha_q16_o,
  output logic               budget_dropped_o,
  output logic [FRAME_W-1:0] frame_count_o,
  output logic [TOTAL_W-1:0] elapsed_ns_o,
  output logic [TOTAL_W-1:0] unscaled_elapsed_ns_o,
  output logic               last_o
);

  localparam int unsigned CNT_W = $clog2(ALPHA_W);
  localparam int unsigned PROD_W = NS_W + SCALE_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_ACCUM = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [NS_W-1:0]    ud_q, ud_d;
  logic [SD_W-1:0]    sd_q, sd_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [TOTAL_W-1:0] stot_q, stot_d;
  logic [TOTAL_W-1:0] utot_q, utot_d;
  logic [FRAME_W-1:0] frames_q, frames_d;
  logic [STEP_W-1:0]  steps_q, steps_d;
  logic               dropped_q, dropped_d;
  logic [NS_W-1:0]    rem_q, rem_d;
  logic [ALPHA_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic [NS_W-1:0]    ud_clamp;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   alu_a;
  logic [ACC_W-1:0]   alu_diff;
  logic               alu_ge;

  // Clamp the raw delta: negatives to zero, large values to the maximum
  always_comb begin
    if (raw_delta_ns_i[RAW_W-1]) begin
      ud_clamp = '0;
    end else if ((raw_delta_ns_i[RAW_W-2:NS_W] != '0) ||
                 (raw_delta_ns_i[NS_W-1:0] > cfg_i.max_delta_ns)) begin
      ud_clamp = cfg_i.max_delta_ns;
    end else begin
      ud_clamp = raw_delta_ns_i[NS_W-1:0];
    end
  end

  assign prod    = ud_q * cfg_i.time_scale_q8;
  assign acc_sum = {1'b0, acc_q} + {(ACC_W + 1 - SD_W)'(0), sd_q};

  // Shared unit: accumulator during steps, shifted remainder during division
  assign alu_a = (state_q == S_DIV) ? {(ACC_W - NS_W - 1)'(0), rem_q, 1'b0} : acc_q;

  fta_alu u_alu (
    .a_i    (alu_a),
    .b_i    (cfg_i.fixed_step_ns),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    ud_d      = ud_q;
    sd_d      = sd_q;
    acc_d     = acc_q;
    stot_d    = stot_q;
    utot_d    = utot_q;
    frames_d  = frames_q;
    steps_d   = steps_q;
    dropped_d = dropped_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    cnt_d     = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ud_d    = ud_clamp;
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        sd_d    = cfg_i.paused ? '0 : prod[PROD_W-1:8];
        state_d = S_ACCUM;
      end
      S_ACCUM: begin
        // add into totals; saturate the accumulator
        acc_d     = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
        stot_d    = stot_q + TOTAL_W'(sd_q);
        utot_d    = utot_q + TOTAL_W'(ud_q);
        frames_d  = frames_q + FRAME_W'(1);
        steps_d   = '0;
        dropped_d = 1'b0;
        state_d   = S_STEP;
      end
      S_STEP: begin
        quot_d = '0;
        cnt_d  = '0;
        if (alu_ge && (steps_q >= cfg_i.max_steps)) begin
          // budget spent with debt left: drop it
          acc_d     = '0;
          dropped_d = 1'b1;
          rem_d     = '0;
          state_d   = S_DIV;
        end else if (alu_ge) begin
          acc_d   = alu_diff;
          state_d = S_EMIT;
        end else begin
          // accumulator is below one step here, so it fits the remainder
          rem_d   = acc_q[NS_W-1:0];
          state_d = S_DIV;
        end
      end
      S_EMIT: begin
        if (out_ready_i) begin
          steps_d = steps_q + STEP_W'(1);
          state_d = S_STEP;
        end
      end
      S_DIV: begin
        // one restoring division bit per cycle
        rem_d  = alu_ge ? alu_diff[NS_W-1:0] : {rem_q[NS_W-2:0], 1'b0};
        quot_d = {quot_q[ALPHA_W-2:0], alu_ge};
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ALPHA_W - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      acc_q     <= '0;
      stot_q    <= '0;
      utot_q    <= '0;
      frames_q  <= '0;
      steps_q   <= '0;
      dropped_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      stot_q    <= stot_d;
      utot_q    <= utot_d;
      frames_q  <= frames_d;
      steps_q   <= steps_d;
      dropped_q <= dropped_d;
      cnt_q     <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ud_q   <= ud_d;
    sd_q   <= sd_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  // Results are held in registers while the sequencer waits for the transfer
  assign in_ready_o            = (state_q == S_IDLE);
  assign out_valid_o           = (state_q == S_EMIT) || (state_q == S_DONE);
  assign is_step_o             = (state_q == S_EMIT);
  assign last_o                = (state_q == S_DONE);
  assign step_index_o          = steps_q;
  assign scaled_delta_ns_o     = sd_q;
  assign unscaled_delta_ns_o   = ud_q;
  assign alpha_q16_o           = (state_q == S_DONE) ? quot_q : '0;
  assign budget_dropped_o      = (state_q == S_DONE) && dropped_q;
  assign frame_count_o         = frames_q;
  assign elapsed_ns_o          = stot_q;
  assign unscaled_elapsed_ns_o = utot_q;

endmodule

// File: design/fixed_timestep_accumulator_unit.sv
// Top level of the fixed-timestep accumulator: configuration registers and frame core.
// The first step result follows the scale, accumulate and step states after the input transfer.
// One frame is taken at a time: a new input is accepted only back in idle, after the granted
// steps (each a step check and an emit) and the 16-bit alpha division on the shared subtractor.
// Reset: asynchronous, active low; clears all totals and loads register defaults.
module fixed_timestep_accumulator_unit import fta_pkg::*; #(
  parameter int unsigned MAX_STEPS_BOUND = MAX_STEPS_BOUND_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [RAW_W-1:0]     raw_delta_ns_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 is_step_o,
  output logic [STEP_W-1:0]    step_index_o,
  output logic [SD_W-1:0]      scaled_delta_ns_o,
  output logic [NS_W-1:0]      unscaled_delta_ns_o,
  output logic [ALPHA_W-1:0]   alpha_q16_o,
  output logic                 budget_dropped_o,
  output logic [FRAME_W-1:0]   frame_count_o,
  output logic [TOTAL_W-1:0]   elapsed_ns_o,
  output logic [TOTAL_W-1:0]   unscaled_elapsed_ns_o,
  output logic                 last_o
);

  fta_cfg_t cfg;

  // Hold the sanitised configuration
  fta_cfg #(
    .MAX_STEPS_BOUND (MAX_STEPS_BOUND)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance one frame per input transfer
  fta_core u_core (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .raw_delta_ns_i        (raw_delta_ns_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .is_step_o             (is_step_o),
    .step_index_o          (step_index_o),
    .scaled_delta_ns_o     (scaled_delta_ns_o),
    .unscaled_delta_ns_o   (unscaled_delta_ns_o),
    .alpha_q16_o           (alpha_q16_o),
    .budget_dropped_o      (budget_dropped_o),
    .frame_count_o         (frame_count_o),
    .elapsed_ns_o          (elapsed_ns_o),
    .unscaled_elapsed_ns_o (unscaled_elapsed_ns_o),
    .last_o                (last_o)
  );

endmodule
